[design/hsvc_pkg.sv]
package hsvc_pkg;

  localparam int unsigned UNIT_W = 17;
  localparam int unsigned SEXT_W = 3;
  localparam int unsigned COMP_W = 16;

  localparam logic [UNIT_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [SEXT_W-1:0] SEXT_0 = 3'd0;
  localparam logic [SEXT_W-1:0] SEXT_1 = 3'd1;
  localparam logic [SEXT_W-1:0] SEXT_2 = 3'd2;
  localparam logic [SEXT_W-1:0] SEXT_3 = 3'd3;
  localparam logic [SEXT_W-1:0] SEXT_4 = 3'd4;
  localparam logic [SEXT_W-1:0] SEXT_5 = 3'd5;

  typedef struct packed {
    logic [SEXT_W-1:0] sextant;
    logic [UNIT_W-1:0] frac;
    logic [UNIT_W-1:0] sat;
    logic [UNIT_W-1:0] bri;
  } prep_t;

endpackage

[design/hsvc_prep.sv]
module hsvc_prep
  import hsvc_pkg::*;
(
  input  logic [15:0]        hue,
  input  logic signed [17:0] saturation,
  input  logic signed [17:0] brightness,
  output prep_t              prep
);

  logic [18:0] h6;
  logic [15:0] frac_raw;

  function automatic logic [UNIT_W-1:0] clamp_unit(input logic [17:0] raw);
    logic [UNIT_W-1:0] res;
    if (raw[17]) begin
      res = '0;
    end else if (raw[16] && (raw[15:0] != 16'd0)) begin
      res = ONE_Q16;
    end else begin
      res = raw[16:0];
    end
    return res;
  endfunction

  // hue * 6 as (hue << 2) + (hue << 1)
  assign h6       = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
  assign frac_raw = h6[15:0];

  always_comb begin
    prep.sextant = h6[18:16];
    if (h6[16]) begin
      prep.frac = {1'b0, frac_raw};
    end else begin
      prep.frac = ONE_Q16 - {1'b0, frac_raw};
    end
    prep.sat = clamp_unit(saturation);
    prep.bri = clamp_unit(brightness);
  end

endmodule

[design/hsv_to_rgb_converter.sv]
// channel  | handshake    | fields
// ---------+--------------+--------------------------------
// input    | start / busy | hue, saturation, brightness
// output   | done         | red, green, blue
//
// four register stages: clamp and sextant, two 17x17 products, 17x33 product,
// final scale and sextant routing. one word per cycle.
// busy is always low; a word may enter on every clock edge.
// rst clears the valid bits of all stages; payload registers are not reset.
// the receiver cannot stall, so done pulses for exactly one cycle per word.
module hsv_to_rgb_converter
  import hsvc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        hue,
  input  logic signed [17:0] saturation,
  input  logic signed [17:0] brightness,
  output logic               done,
  output logic [15:0]        red,
  output logic [15:0]        green,
  output logic [15:0]        blue
);

  prep_t prep_in;
  prep_t s1;
  logic  s1_valid;

  logic [SEXT_W-1:0] s2_sextant;
  logic [UNIT_W-1:0] s2_bri;
  logic [33:0]       s2_sf;
  logic [33:0]       s2_bu;
  logic              s2_valid;

  logic [SEXT_W-1:0] s3_sextant;
  logic [49:0]       s3_prod;
  logic [COMP_W-1:0] s3_v;
  logic [COMP_W-1:0] s3_m;
  logic              s3_valid;

  logic [33:0]       t_full;
  logic [32:0]       t_val;
  logic [49:0]       mq;
  logic [65:0]       nq;
  logic [COMP_W-1:0] n_val;
  logic [COMP_W-1:0] red_next;
  logic [COMP_W-1:0] green_next;
  logic [COMP_W-1:0] blue_next;

  function automatic logic [COMP_W-1:0] vq_sub(input logic [UNIT_W-1:0] b);
    logic [32:0] d;
    d = {b, 16'd0} - {16'd0, b};
    return d[31:16];
  endfunction

  hsvc_prep u_prep (
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .prep       (prep_in)
  );

  assign busy = 1'b0;

  // stage 1: clamped operands and sextant
  always_ff @(posedge clk) begin
    s1 <= prep_in;
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
  end

  // stage 2: s*f and b*(1-s)
  always_ff @(posedge clk) begin
    s2_sextant <= s1.sextant;
    s2_bri     <= s1.bri;
    s2_sf      <= {17'd0, s1.sat} * {17'd0, s1.frac};
    s2_bu      <= {17'd0, s1.bri} * {17'd0, ONE_Q16 - s1.sat};
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  // stage 3: b*(2^32 - s*f), plus v from b*65535 = (b << 16) - b and m from b*(1-s)*65535
  assign t_full = 34'h1_0000_0000 - s2_sf;
  assign t_val  = t_full[32:0];
  assign mq     = {s2_bu[33:0], 16'd0} - {16'd0, s2_bu};

  always_ff @(posedge clk) begin
    s3_sextant <= s2_sextant;
    s3_prod    <= {33'd0, s2_bri} * {17'd0, t_val};
    s3_m       <= mq[47:32];
    s3_v       <= vq_sub(s2_bri);
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  // stage 4: n = (P*65535) >> 48, then route by sextant
  assign nq    = {s3_prod, 16'd0} - {16'd0, s3_prod};
  assign n_val = nq[63:48];

  always_comb begin
    unique case (s3_sextant)
      SEXT_1: begin
        red_next = n_val; green_next = s3_v;  blue_next = s3_m;
      end
      SEXT_2: begin
        red_next = s3_m;  green_next = s3_v;  blue_next = n_val;
      end
      SEXT_3: begin
        red_next = s3_m;  green_next = n_val; blue_next = s3_v;
      end
      SEXT_4: begin
        red_next = n_val; green_next = s3_m;  blue_next = s3_v;
      end
      SEXT_5: begin
        red_next = s3_v;  green_next = s3_m;  blue_next = n_val;
      end
      default: begin
        red_next = s3_v;  green_next = n_val; blue_next = s3_m;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
  end

endmodule
